// ===== hw/rtl/spcr_pkg.sv =====
// Shared types and constants for the sphere pair collision resolver.
// No dependencies.
package spcr_pkg;

   localparam int ROOT_STEPS = 32;
   localparam int QUOT_STEPS = 32;

   typedef logic signed [31:0] coord_type;

   typedef struct packed {
      logic                  hit;
      coord_type [2:0]       a;
      coord_type [2:0]       b;
      logic      [2:0]       neg;
      logic      [2:0][31:0] mag;
      logic      [31:0]      rsum;
   } pair_type;

   typedef struct packed {
      logic [63:0] rad;
      logic [34:0] rem;
      logic [31:0] root;
   } root_type;

   typedef struct packed {
      logic [31:0]      divisor;
      logic             zero;
      logic [2:0][32:0] rem;
      logic [2:0][31:0] low;
      logic [2:0][31:0] quo;
   } quot_type;

endpackage

// ===== hw/rtl/spcr_if.sv =====
// Request and response channel interfaces for the collision resolver.
// Depends on nothing.
interface spcr_req_if;
   logic               valid;
   logic               ready;
   logic signed [31:0] first_x;
   logic signed [31:0] first_y;
   logic signed [31:0] first_z;
   logic signed [31:0] second_x;
   logic signed [31:0] second_y;
   logic signed [31:0] second_z;
   logic        [30:0] first_radius;
   logic        [30:0] second_radius;
   modport source (output valid, first_x, first_y, first_z, second_x, second_y, second_z,
                   first_radius, second_radius, input ready);
   modport sink (input valid, first_x, first_y, first_z, second_x, second_y, second_z,
                 first_radius, second_radius, output ready);
endinterface

interface spcr_rsp_if;
   logic               valid;
   logic               ready;
   logic               hit;
   logic signed [31:0] new_first_x;
   logic signed [31:0] new_first_y;
   logic signed [31:0] new_first_z;
   logic signed [31:0] new_second_x;
   logic signed [31:0] new_second_y;
   logic signed [31:0] new_second_z;
   modport source (output valid, hit, new_first_x, new_first_y, new_first_z,
                   new_second_x, new_second_y, new_second_z, input ready);
   modport sink (input valid, hit, new_first_x, new_first_y, new_first_z,
                 new_second_x, new_second_y, new_second_z, output ready);
endinterface

// ===== hw/rtl/spcr_sqrt_cell.sv =====
// One restoring square root step: one root bit per cell.
// Depends on spcr_pkg.
module spcr_sqrt_cell (
   input  logic               clock,
   input  logic               reset,
   input  logic               advance,
   input  logic               valid_in,
   input  spcr_pkg::pair_type pair_in,
   input  spcr_pkg::root_type root_in,
   output logic               valid_ff,
   output spcr_pkg::pair_type pair_ff,
   output spcr_pkg::root_type root_ff
);
   logic [34:0]        rem_sh;
   logic [34:0]        trial;
   spcr_pkg::root_type root_in_next;

   always_comb begin
      rem_sh = {root_in.rem[32:0], root_in.rad[63:62]};
      trial  = {1'b0, root_in.root, 2'b01};
      root_in_next.rad = {root_in.rad[61:0], 2'b00};
      if (rem_sh >= trial) begin
         root_in_next.rem  = rem_sh - trial;
         root_in_next.root = {root_in.root[30:0], 1'b1};
      end else begin
         root_in_next.rem  = rem_sh;
         root_in_next.root = {root_in.root[30:0], 1'b0};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (advance) begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         pair_ff <= pair_in;
         root_ff <= root_in_next;
      end
   end
endmodule

// ===== hw/rtl/spcr_div_cell.sv =====
// One restoring division step on three lanes: one quotient bit per cell.
// Depends on spcr_pkg.
module spcr_div_cell (
   input  logic               clock,
   input  logic               reset,
   input  logic               advance,
   input  logic               valid_in,
   input  spcr_pkg::pair_type pair_in,
   input  spcr_pkg::quot_type quot_in,
   output logic               valid_ff,
   output spcr_pkg::pair_type pair_ff,
   output spcr_pkg::quot_type quot_ff
);
   logic [32:0]        sh;
   spcr_pkg::quot_type quot_in_next;

   always_comb begin
      quot_in_next      = quot_in;
      sh                = '0;
      for (int k = 0; k < 3; k++) begin
         sh = {quot_in.rem[k][31:0], quot_in.low[k][31]};
         quot_in_next.low[k] = {quot_in.low[k][30:0], 1'b0};
         if (sh >= {1'b0, quot_in.divisor}) begin
            quot_in_next.rem[k] = sh - {1'b0, quot_in.divisor};
            quot_in_next.quo[k] = {quot_in.quo[k][30:0], 1'b1};
         end else begin
            quot_in_next.rem[k] = sh;
            quot_in_next.quo[k] = {quot_in.quo[k][30:0], 1'b0};
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (advance) begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         pair_ff <= pair_in;
         quot_ff <= quot_in_next;
      end
   end
endmodule

// ===== hw/rtl/sphere_pair_collision_resolve_top.sv =====
// Sphere pair collision resolver: contact test, centre distance, push-out.
// One item accepted every cycle while the output register is not stalled waiting for rsp ready.
// Pipeline: 3 front stages, 32 square root cells, 2 stages, 32 divider cells and the output.
// The whole pipe holds while the output register waits for rsp ready.
// Synchronous reset clears all valid bits; payload registers are not reset.
// Depends on spcr_pkg, spcr_if, spcr_sqrt_cell and spcr_div_cell.
module sphere_pair_collision_resolve_top (
   input logic       clock,
   input logic       reset,
   spcr_req_if.sink  req_chan,
   spcr_rsp_if.source rsp_chan
);
   logic advance;

   // front: differences
   logic                        s0_valid_ff;
   spcr_pkg::coord_type [2:0]   s0_a_ff, s0_b_ff;
   logic [2:0][32:0]            s0_mag_ff;
   logic [2:0]                  s0_neg_ff;
   logic [31:0]                 s0_rsum_ff;
   spcr_pkg::coord_type [2:0]   a_in, b_in;
   logic [2:0][32:0]            mag_in;
   logic [2:0]                  neg_in;
   logic [32:0]                 diff;

   // squares
   logic                        s1_valid_ff;
   spcr_pkg::coord_type [2:0]   s1_a_ff, s1_b_ff;
   logic [2:0][32:0]            s1_mag_ff;
   logic [2:0]                  s1_neg_ff;
   logic [31:0]                 s1_rsum_ff;
   logic [2:0][63:0]            s1_sq_ff;
   logic [63:0]                 s1_rsq_ff;

   // contact test
   logic                        s2_valid_ff;
   spcr_pkg::pair_type          s2_pair_ff;
   spcr_pkg::root_type          s2_root_ff;
   logic [66:0]                 sum;

   logic [spcr_pkg::ROOT_STEPS:0] rv;
   spcr_pkg::pair_type            rp [spcr_pkg::ROOT_STEPS+1];
   spcr_pkg::root_type            rr [spcr_pkg::ROOT_STEPS+1];

   // products
   logic                        sp_valid_ff;
   spcr_pkg::pair_type          sp_pair_ff;
   logic [31:0]                 sp_dist_ff;
   logic [2:0][63:0]            sp_prod_ff;
   logic [31:0]                 pen;

   // numerator
   logic                        sn_valid_ff;
   spcr_pkg::pair_type          sn_pair_ff;
   spcr_pkg::quot_type          sn_quot_ff;
   logic [2:0][64:0]            num;

   logic [spcr_pkg::QUOT_STEPS:0] qv;
   spcr_pkg::pair_type            qp [spcr_pkg::QUOT_STEPS+1];
   spcr_pkg::quot_type            qq [spcr_pkg::QUOT_STEPS+1];

   // output
   logic                        rsp_valid_ff;
   logic                        rsp_hit_ff;
   spcr_pkg::coord_type [2:0]   rsp_first_ff, rsp_second_ff;
   spcr_pkg::coord_type [2:0]   first_in, second_in;
   logic signed [33:0]          moved_a, moved_b;
   logic signed [33:0]          step;

   function automatic spcr_pkg::coord_type sat34(input logic signed [33:0] v);
      spcr_pkg::coord_type r;
      if (v > 34'sd2147483647) begin
         r = 32'sh7fffffff;
      end else if (v < -34'sd2147483648) begin
         r = 32'sh80000000;
      end else begin
         r = v[31:0];
      end
      return r;
   endfunction

   function automatic logic [64:0] num_of(input logic [63:0] p, input logic [31:0] d);
      return {1'b0, p} + {34'd0, d[31:1]};
   endfunction

   assign advance        = !rsp_valid_ff || rsp_chan.ready;
   assign req_chan.ready = advance;

   always_comb begin
      a_in[0] = req_chan.first_x;
      a_in[1] = req_chan.first_y;
      a_in[2] = req_chan.first_z;
      b_in[0] = req_chan.second_x;
      b_in[1] = req_chan.second_y;
      b_in[2] = req_chan.second_z;
      diff    = '0;
      for (int k = 0; k < 3; k++) begin
         diff      = {b_in[k][31], b_in[k]} - {a_in[k][31], a_in[k]};
         neg_in[k] = diff[32];
         mag_in[k] = diff[32] ? (33'd0 - diff) : diff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s0_valid_ff <= 1'b0;
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
         sp_valid_ff <= 1'b0;
         sn_valid_ff <= 1'b0;
      end else if (advance) begin
         s0_valid_ff <= req_chan.valid;
         s1_valid_ff <= s0_valid_ff;
         s2_valid_ff <= s1_valid_ff;
         sp_valid_ff <= rv[spcr_pkg::ROOT_STEPS];
         sn_valid_ff <= sp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         s0_a_ff    <= a_in;
         s0_b_ff    <= b_in;
         s0_mag_ff  <= mag_in;
         s0_neg_ff  <= neg_in;
         s0_rsum_ff <= {1'b0, req_chan.first_radius} + {1'b0, req_chan.second_radius};
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         s1_a_ff    <= s0_a_ff;
         s1_b_ff    <= s0_b_ff;
         s1_mag_ff  <= s0_mag_ff;
         s1_neg_ff  <= s0_neg_ff;
         s1_rsum_ff <= s0_rsum_ff;
         s1_rsq_ff  <= s0_rsum_ff * s0_rsum_ff;
         for (int k = 0; k < 3; k++) begin
            s1_sq_ff[k] <= s0_mag_ff[k][31:0] * s0_mag_ff[k][31:0];
         end
      end
   end

   assign sum = {3'b000, s1_sq_ff[0]} + {3'b000, s1_sq_ff[1]} + {3'b000, s1_sq_ff[2]};

   always_ff @(posedge clock) begin
      if (advance) begin
         s2_pair_ff.hit  <= (sum <= {3'b000, s1_rsq_ff});
         s2_pair_ff.a    <= s1_a_ff;
         s2_pair_ff.b    <= s1_b_ff;
         s2_pair_ff.neg  <= s1_neg_ff;
         s2_pair_ff.rsum <= s1_rsum_ff;
         for (int k = 0; k < 3; k++) begin
            s2_pair_ff.mag[k] <= s1_mag_ff[k][31:0];
         end
         s2_root_ff.rad  <= sum[63:0];
         s2_root_ff.rem  <= '0;
         s2_root_ff.root <= '0;
      end
   end

   assign rv[0] = s2_valid_ff;
   assign rp[0] = s2_pair_ff;
   assign rr[0] = s2_root_ff;

   for (genvar i = 0; i < spcr_pkg::ROOT_STEPS; i++) begin : g_root
      spcr_sqrt_cell u_cell (
         .clock    (clock),
         .reset    (reset),
         .advance  (advance),
         .valid_in (rv[i]),
         .pair_in  (rp[i]),
         .root_in  (rr[i]),
         .valid_ff (rv[i+1]),
         .pair_ff  (rp[i+1]),
         .root_ff  (rr[i+1])
      );
   end

   assign pen = rp[spcr_pkg::ROOT_STEPS].rsum - rr[spcr_pkg::ROOT_STEPS].root;

   always_ff @(posedge clock) begin
      if (advance) begin
         sp_pair_ff <= rp[spcr_pkg::ROOT_STEPS];
         sp_dist_ff <= rr[spcr_pkg::ROOT_STEPS].root;
         for (int k = 0; k < 3; k++) begin
            sp_prod_ff[k] <= rp[spcr_pkg::ROOT_STEPS].mag[k] * pen;
         end
      end
   end

   always_comb begin
      for (int k = 0; k < 3; k++) begin
         num[k] = num_of(sp_prod_ff[k], sp_dist_ff);
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         sn_pair_ff         <= sp_pair_ff;
         sn_quot_ff.divisor <= sp_dist_ff;
         sn_quot_ff.zero    <= sp_dist_ff == 32'd0;
         sn_quot_ff.quo     <= '0;
         for (int k = 0; k < 3; k++) begin
            sn_quot_ff.rem[k] <= num[k][64:32];
            sn_quot_ff.low[k] <= num[k][31:0];
         end
      end
   end

   assign qv[0] = sn_valid_ff;
   assign qp[0] = sn_pair_ff;
   assign qq[0] = sn_quot_ff;

   for (genvar i = 0; i < spcr_pkg::QUOT_STEPS; i++) begin : g_quot
      spcr_div_cell u_cell (
         .clock    (clock),
         .reset    (reset),
         .advance  (advance),
         .valid_in (qv[i]),
         .pair_in  (qp[i]),
         .quot_in  (qq[i]),
         .valid_ff (qv[i+1]),
         .pair_ff  (qp[i+1]),
         .quot_ff  (qq[i+1])
      );
   end

   always_comb begin
      moved_a = '0;
      moved_b = '0;
      step    = '0;
      for (int k = 0; k < 3; k++) begin
         step = {2'b00, qq[spcr_pkg::QUOT_STEPS].quo[k]};
         if (qp[spcr_pkg::QUOT_STEPS].neg[k]) begin
            step = -step;
         end
         moved_a = {{2{qp[spcr_pkg::QUOT_STEPS].a[k][31]}}, qp[spcr_pkg::QUOT_STEPS].a[k]} - step;
         moved_b = {{2{qp[spcr_pkg::QUOT_STEPS].b[k][31]}}, qp[spcr_pkg::QUOT_STEPS].b[k]} + step;
         if (qp[spcr_pkg::QUOT_STEPS].hit && !qq[spcr_pkg::QUOT_STEPS].zero) begin
            first_in[k]  = sat34(moved_a);
            second_in[k] = sat34(moved_b);
         end else begin
            first_in[k]  = qp[spcr_pkg::QUOT_STEPS].a[k];
            second_in[k] = qp[spcr_pkg::QUOT_STEPS].b[k];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         rsp_valid_ff <= qv[spcr_pkg::QUOT_STEPS];
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         rsp_hit_ff    <= qp[spcr_pkg::QUOT_STEPS].hit;
         rsp_first_ff  <= first_in;
         rsp_second_ff <= second_in;
      end
   end

   assign rsp_chan.valid        = rsp_valid_ff;
   assign rsp_chan.hit          = rsp_hit_ff;
   assign rsp_chan.new_first_x  = rsp_first_ff[0];
   assign rsp_chan.new_first_y  = rsp_first_ff[1];
   assign rsp_chan.new_first_z  = rsp_first_ff[2];
   assign rsp_chan.new_second_x = rsp_second_ff[0];
   assign rsp_chan.new_second_y = rsp_second_ff[1];
   assign rsp_chan.new_second_z = rsp_second_ff[2];
endmodule

// ===== sim/spcr_tb_if.sv =====
// Item types for the collision resolver bench; the channel interfaces come from spcr_if.
// No dependencies.
package spcr_tb_pkg;

   typedef struct {
      logic signed [31:0] ax, ay, az, bx, by, bz;
      logic        [30:0] ra, rb;
   } pair_item_type;

   typedef struct {
      logic               hit;
      logic signed [31:0] fx, fy, fz, sx, sy, sz;
   } contact_type;
endpackage

// ===== sim/sphere_pair_collision_resolve_top_tb.sv =====
// Self-checking bench for the sphere pair collision resolver: random and directed pairs,
// predicted contact and push-out compared item by item. Depends on spcr_pkg, spcr_if,
// spcr_tb_pkg and the resolver RTL.
module sphere_pair_collision_resolve_top_tb;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int CYCLE_LIMIT = 1000000;

   logic clock = 1'b0;
   logic reset = 1'b1;
   spcr_req_if req_chan ();
   spcr_rsp_if rsp_chan ();

   sphere_pair_collision_resolve_top u_top (
      .clock(clock), .reset(reset), .req_chan(req_chan.sink), .rsp_chan(rsp_chan.source)
   );

   spcr_tb_pkg::pair_item_type pending_pairs[$];
   spcr_tb_pkg::contact_type   expected_contacts[$];
   int unsigned send_gap = 0, recv_gap = 0, cycles = 0;
   int mismatches = 0, received = 0, hits = 0, sent = 0;
   bit hold_off = 0, stim_done = 0;

   initial begin
      forever #4 clock = ~clock;
   end

   function automatic logic [32:0] root66(logic [65:0] v);
      logic [35:0] rem;
      logic [32:0] root;
      logic [35:0] trial;
      rem = '0;
      root = '0;
      for (int i = 32; i >= 0; i--) begin
         rem = {rem[33:0], v[2*i+1 -: 2]};
         trial = {1'b0, root, 2'b01};
         if (rem >= trial) begin
            rem = rem - trial;
            root = {root[31:0], 1'b1};
         end else begin
            root = {root[31:0], 1'b0};
         end
      end
      return root;
   endfunction

   function automatic logic signed [31:0] clamp32(longint v);
      if (v > 64'sd2147483647) return 32'sh7fffffff;
      if (v < -64'sd2147483648) return 32'sh80000000;
      return v[31:0];
   endfunction

   function automatic spcr_tb_pkg::contact_type resolve_contact(spcr_tb_pkg::pair_item_type p);
      spcr_tb_pkg::contact_type r;
      longint a[3], b[3], d[3];
      logic [65:0] sq;
      logic [63:0] m, rsq, step;
      logic [31:0] rsum;
      logic [32:0] span;
      logic [63:0] pen;
      logic [127:0] num;
      a[0] = p.ax; a[1] = p.ay; a[2] = p.az;
      b[0] = p.bx; b[1] = p.by; b[2] = p.bz;
      sq = '0;
      for (int k = 0; k < 3; k++) begin
         d[k] = b[k] - a[k];
         m = (d[k] < 0) ? -d[k] : d[k];
         sq = sq + {2'b00, m * m};
      end
      rsum = {1'b0, p.ra} + {1'b0, p.rb};
      rsq = 64'(rsum) * 64'(rsum);
      r.hit = (sq[65:64] == 0) && (sq[63:0] <= rsq);
      r.fx = p.ax; r.fy = p.ay; r.fz = p.az;
      r.sx = p.bx; r.sy = p.by; r.sz = p.bz;
      if (!r.hit) return r;
      span = root66(sq);
      if (span == 0) return r;
      pen = (span <= rsum) ? rsum - span : 0;
      for (int k = 0; k < 3; k++) begin
         m = (d[k] < 0) ? -d[k] : d[k];
         num = 128'(m) * 128'(pen) + 128'(span / 2);
         step = 64'(num / 128'(span));
         if (d[k] < 0) begin
            a[k] = a[k] + longint'(step);
            b[k] = b[k] - longint'(step);
         end else begin
            a[k] = a[k] - longint'(step);
            b[k] = b[k] + longint'(step);
         end
      end
      r.fx = clamp32(a[0]); r.fy = clamp32(a[1]); r.fz = clamp32(a[2]);
      r.sx = clamp32(b[0]); r.sy = clamp32(b[1]); r.sz = clamp32(b[2]);
      return r;
   endfunction

   function automatic logic signed [31:0] rand_coord(int mode);
      case (mode)
         0: return $urandom;
         1: return $signed($urandom_range(0, 32'h3ffff)) - 32'sh20000;
         default: return $signed($urandom_range(0, 32'h3ff)) - 32'sh200;
      endcase
   endfunction

   function automatic logic [30:0] rand_radius(int mode);
      case (mode)
         0: return 31'($urandom);
         1: return 31'($urandom_range(0, 32'h3ffff));
         default: return 31'($urandom_range(0, 32'h3ff));
      endcase
   endfunction

   function automatic spcr_tb_pkg::pair_item_type make_pair(
         logic signed [31:0] ax, ay, az, bx, by, bz, logic [30:0] ra, rb);
      spcr_tb_pkg::pair_item_type p;
      p.ax = ax; p.ay = ay; p.az = az; p.bx = bx; p.by = by; p.bz = bz;
      p.ra = ra; p.rb = rb;
      return p;
   endfunction

   task automatic queue_pairs();
      spcr_tb_pkg::pair_item_type p;
      int mode;
      // extremes, coincident centres, exact touch, clear miss, saturation
      pending_pairs.push_back(make_pair(0, 0, 0, 0, 0, 0, 0, 0));
      pending_pairs.push_back(make_pair(5, 5, 5, 5, 5, 5, 7, 9));
      pending_pairs.push_back(make_pair(0, 0, 0, 3, 4, 0, 2, 3));
      pending_pairs.push_back(make_pair(0, 0, 0, 3, 4, 0, 2, 2));
      pending_pairs.push_back(make_pair(0, 0, 0, 6, 8, 0, 2, 2));
      pending_pairs.push_back(make_pair(32'sh80000000, 32'sh80000000, 32'sh80000000,
                                        32'sh7fffffff, 32'sh7fffffff, 32'sh7fffffff,
                                        31'h7fffffff, 31'h7fffffff));
      pending_pairs.push_back(make_pair(32'sh80000000, 0, 0, 32'sh7fffffff, 0, 0,
                                        31'h7fffffff, 31'h7fffffff));
      pending_pairs.push_back(make_pair(32'sh7fffffff, 0, 0, 32'sh7ffffff0, 0, 0,
                                        31'h7fffffff, 31'h7fffffff));
      pending_pairs.push_back(make_pair(32'sh80000010, 0, 0, 32'sh80000000, 0, 0,
                                        31'h7fffffff, 0));
      pending_pairs.push_back(make_pair(0, 32'sh80000000, 0, 0, 32'sh7fffffff, 0, 0, 0));
      pending_pairs.push_back(make_pair(-1, -1, -1, 1, 1, 1, 1, 1));
      pending_pairs.push_back(make_pair(0, 0, 0, 1, 0, 0, 0, 0));
      pending_pairs.push_back(make_pair(0, 0, 0, 0, 0, 1, 1, 0));
      pending_pairs.push_back(make_pair(100, -100, 7, 90, -95, 3, 31'h7fffffff, 0));
      for (int i = 0; i < 1100; i++) begin
         mode = $urandom_range(0, 9);
         mode = (mode < 2) ? 0 : (mode < 6) ? 1 : 2;
         p = make_pair(rand_coord(mode), rand_coord(mode), rand_coord(mode),
                       rand_coord(mode), rand_coord(mode), rand_coord(mode),
                       rand_radius(mode), rand_radius(mode));
         if ($urandom_range(0, 15) == 0) begin
            p.bx = p.ax; p.by = p.ay; p.bz = p.az;
         end
         pending_pairs.push_back(p);
      end
   endtask

   function automatic int unsigned pick_gap();
      int unsigned r;
      r = $urandom_range(0, 99);
      if (r < 55) return 0;
      if (r < 92) return $urandom_range(1, 3);
      return $urandom_range(10, 40);
   endfunction

   initial begin
      req_chan.valid = 1'b0;
      req_chan.first_x = '0; req_chan.first_y = '0; req_chan.first_z = '0;
      req_chan.second_x = '0; req_chan.second_y = '0; req_chan.second_z = '0;
      req_chan.first_radius = '0; req_chan.second_radius = '0;
      rsp_chan.ready = 1'b0;
      queue_pairs();
      repeat (4) @(posedge clock);
      reset <= 1'b0;
   end

   // driver
   always @(posedge clock) begin
      if (!reset) begin
         if (req_chan.valid && req_chan.ready) begin
            expected_contacts.push_back(resolve_contact(make_pair(
               req_chan.first_x, req_chan.first_y, req_chan.first_z,
               req_chan.second_x, req_chan.second_y, req_chan.second_z,
               req_chan.first_radius, req_chan.second_radius)));
            sent++;
            if (sent == 600) hold_off = 1;
         end
         if (hold_off && expected_contacts.size() == 0 &&
             !(req_chan.valid && req_chan.ready)) begin
            hold_off = 0;
         end
         if (!req_chan.valid || req_chan.ready) begin
            if (send_gap != 0) begin
               send_gap--;
               req_chan.valid <= 1'b0;
            end else if (hold_off || pending_pairs.size() == 0) begin
               req_chan.valid <= 1'b0;
               if (pending_pairs.size() == 0) stim_done = 1;
            end else begin
               spcr_tb_pkg::pair_item_type p;
               p = pending_pairs.pop_front();
               req_chan.valid <= 1'b1;
               req_chan.first_x <= p.ax; req_chan.first_y <= p.ay;
               req_chan.first_z <= p.az;
               req_chan.second_x <= p.bx; req_chan.second_y <= p.by;
               req_chan.second_z <= p.bz;
               req_chan.first_radius <= p.ra; req_chan.second_radius <= p.rb;
               send_gap = ($urandom_range(0, 3) == 0) ? pick_gap() : 0;
            end
         end
      end
   end

   // monitor
   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_chan.valid && rsp_chan.ready) begin
            spcr_tb_pkg::contact_type got, want;
            got.hit = rsp_chan.hit;
            got.fx = rsp_chan.new_first_x; got.fy = rsp_chan.new_first_y;
            got.fz = rsp_chan.new_first_z;
            got.sx = rsp_chan.new_second_x; got.sy = rsp_chan.new_second_y;
            got.sz = rsp_chan.new_second_z;
            received++;
            if (got.hit === 1'b1) hits++;
            if (expected_contacts.size() == 0) begin
               mismatches++;
               if (mismatches <= 10) $display("unexpected item at cycle %0d", cycles);
            end else begin
               want = expected_contacts.pop_front();
               if (got.hit !== want.hit || got.fx !== want.fx || got.fy !== want.fy ||
                   got.fz !== want.fz || got.sx !== want.sx || got.sy !== want.sy ||
                   got.sz !== want.sz) begin
                  mismatches++;
                  if (mismatches <= 10)
                     $display("item %0d: want %b %0d %0d %0d %0d %0d %0d %s",
                              received, want.hit, want.fx, want.fy, want.fz, want.sx,
                              want.sy, want.sz,
                              $sformatf("got %b %0d %0d %0d %0d %0d %0d",
                                        got.hit, got.fx, got.fy, got.fz, got.sx,
                                        got.sy, got.sz));
               end
            end
         end
         if (recv_gap != 0) begin
            recv_gap--;
            rsp_chan.ready <= 1'b0;
         end else begin
            rsp_chan.ready <= 1'b1;
            if ($urandom_range(0, 3) == 0) recv_gap = pick_gap();
         end
      end
   end

   initial begin
      int unsigned tail;
      tail = 0;
      while (!(stim_done && expected_contacts.size() == 0) && cycles < CYCLE_LIMIT) begin
         @(posedge clock);
         cycles++;
      end
      while (tail < 100 && cycles < CYCLE_LIMIT) begin
         @(posedge clock);
         cycles++;
         tail++;
      end
      $display("pairs sent %0d, results checked %0d, contacts %0d, mismatches %0d",
               sent, received, hits, mismatches);
      if (cycles >= CYCLE_LIMIT) begin
         $display("sphere_pair_collision_resolve_top: mismatch");
      end else if (mismatches == 0 && expected_contacts.size() == 0) begin
         $display("sphere_pair_collision_resolve_top: match");
      end else begin
         $display("sphere_pair_collision_resolve_top: mismatch");
      end
      $finish;
   end
endmodule
